// ===== hw/rtl/tga_image_decoder_defines.svh =====
// Assertion macros shared by the decoder modules.
`ifndef TGA_IMAGE_DECODER_DEFINES_SVH
`define TGA_IMAGE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGAD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tgad_pkg.sv =====
// Types, constants and command structures of the TGA image decoder.
`default_nettype none

package tgad_pkg;

    localparam int HDR_LEN      = 18;
    localparam int HDR_PW       = $clog2(HDR_LEN);
    localparam int PAL_DEPTH    = 256;
    localparam int PAL_AW       = $clog2(PAL_DEPTH);
    localparam int MIN_WIDTH    = 4;
    localparam int RAW_MAX      = 127;
    localparam int TDATA_W      = 112;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;

    localparam logic [7:0] TGA_CMAP     = 8'd1;
    localparam logic [7:0] TGA_TRUE     = 8'd2;
    localparam logic [7:0] TGA_CMAP_RLE = 8'd9;
    localparam logic [7:0] TGA_TRUE_RLE = 8'd10;

    typedef enum logic [1:0] {
        K_SIZE = 2'd0,
        K_RUN  = 2'd1,
        K_DONE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_BAD_HDR   = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_NARROW    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_PAL    = 3'd2,
        PH_PACKET = 3'd3,
        PH_PIXEL  = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_HCHECK,
        S_HTOTAL,
        S_HBASE,
        S_HOK,
        S_AFTER_ID,
        S_ENTPIX,
        S_RUNSET,
        S_SEG,
        S_ROWMUL,
        S_FINOK,
        S_ERR,
        S_FIN
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_HDR_WR,
        OP_ID_DEC,
        OP_PAL_ASM,
        OP_PIX_ASM,
        OP_PKT_HDR,
        OP_RUN_SET,
        OP_SEG,
        OP_ROW_MUL,
        OP_TOTAL_MUL,
        OP_BASE0,
        OP_ENTER_ID,
        OP_ENTER_PAL,
        OP_ENTER_PIX,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    emit;
        kind_t   kind;
        status_t status;
        logic    last;
    } dp_cmd_t;

    typedef struct packed {
        logic    last_hdr_byte;
        logic    id_last;
        logic    id_nz;
        logic    is_pal;
        logic    is_rle;
        logic    pal_nz;
        logic    asm_full_pal;
        logic    asm_full_pix;
        logic    pal_fill_done;
        logic    idx_bad;
        status_t hdr_code;
        logic    runset_rem_zero;
        logic    seg_wrap;
        logic    seg_row_more;
        logic    seg_full;
        logic    seg_left_zero;
        logic    left_nz;
        logic    end_flag;
        logic    out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgad_dp.sv =====
// Datapath of the TGA decoder: header store, palette memory, counters and result register.
`default_nettype none
`include "tga_image_decoder_defines.svh"

module tgad_dp import tgad_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         s_axis_tdata,
    input  wire logic               s_axis_tlast,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]              m_axis_tuser,
    output logic                    m_axis_tlast
);

    logic [7:0]        byte_reg, byte_next;
    logic              end_reg, end_next;
    logic [HDR_PW-1:0] pos_reg, pos_next;
    logic [7:0]        hdr_reg [HDR_LEN];
    logic [7:0]        hdr_next [HDR_LEN];
    logic [8:0]        loaded_reg, loaded_next;
    logic [23:0]       asm_reg, asm_next;
    logic [1:0]        acnt_reg, acnt_next;
    logic [7:0]        rem_reg, rem_next;
    logic              rep_reg, rep_next;
    logic [15:0]       row_reg, row_next;
    logic [15:0]       col_reg, col_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       done_reg, done_next;
    logic [31:0]       total_reg, total_next;
    logic [7:0]        left_reg, left_next;
    logic [31:0]       argb_reg, argb_next;
    logic [31:0]       pal_rd_reg;
    logic [31:0]       pal_mem [PAL_DEPTH];

    logic              ovalid_reg, ovalid_next;
    kind_t             okind_reg, okind_next;
    status_t           ostat_reg, ostat_next;
    logic [15:0]       ow_reg, ow_next, oh_reg, oh_next;
    logic [31:0]       oidx_reg, oidx_next;
    logic [7:0]        ocnt_reg, ocnt_next;
    logic [31:0]       oargb_reg, oargb_next;
    logic              olast_reg, olast_next;

    logic [15:0] w, h, yorig;
    logic [7:0]  ptype;
    logic [4:0]  nb_pal, nb_pix;
    logic [23:0] asm_part;
    logic [31:0] shifted;
    logic [31:0] val_pal, val_pix;
    logic [8:0]  loaded_inc;
    logic        pal_we;
    logic [16:0] room, col_sum, row_inc;
    logic [7:0]  seg;
    logic [32:0] done_sum;
    logic [15:0] mul_row, dest, mul_b;
    logic [31:0] prod;
    logic        out_free;
    status_t     hcode;

    function automatic logic [31:0] asm_val(input logic [23:0] a, input logic [7:0] b,
                                            input logic [4:0] nb);
        if (nb == 5'd4) begin
            return {b, a};
        end
        return {ALPHA_OPAQUE, a} | {8'h00, b, 16'h0000};
    endfunction

    assign w     = {hdr_reg[13], hdr_reg[12]};
    assign h     = {hdr_reg[15], hdr_reg[14]};
    assign yorig = {hdr_reg[11], hdr_reg[10]};
    assign ptype = hdr_reg[2];
    assign nb_pal = hdr_reg[7][7:3];
    assign nb_pix = hdr_reg[16][7:3];

    assign shifted  = {24'h0, byte_reg} << {acnt_reg, 3'b000};
    assign asm_part = asm_reg | shifted[23:0];
    assign val_pal  = asm_val(asm_reg, byte_reg, nb_pal);
    assign val_pix  = asm_val(asm_reg, byte_reg, nb_pix);
    assign loaded_inc = loaded_reg + 9'd1;

    // Run segment never crosses the end of the current row.
    assign room     = {1'b0, w} - {1'b0, col_reg};
    assign seg      = ({9'h000, left_reg} < room) ? left_reg : room[7:0];
    assign col_sum  = {1'b0, col_reg} + {9'h000, seg};
    assign row_inc  = {1'b0, row_reg} + 17'd1;
    assign done_sum = {1'b0, done_reg} + {25'h0, seg};

    // One shared 16x16 multiplier for the pixel total and the row base index.
    assign mul_row = (cmd.op == OP_BASE0) ? 16'h0000 : row_reg;
    assign dest    = (yorig == 16'h0000) ? (h - 16'd1 - mul_row) : mul_row;
    assign mul_b   = (cmd.op == OP_TOTAL_MUL) ? h : dest;
    assign prod    = {16'h0000, w} * {16'h0000, mul_b};

    always_comb begin
        hcode = ST_OK;
        if (w == 16'h0000 || h == 16'h0000) begin
            hcode = ST_ZERO_SIZE;
        end else if (w < 16'(MIN_WIDTH)) begin
            hcode = ST_NARROW;
        end else if (ptype == TGA_CMAP || ptype == TGA_CMAP_RLE) begin
            if (hdr_reg[1] == 8'h00 || hdr_reg[3] != 8'h00 || hdr_reg[4] != 8'h00 ||
                hdr_reg[6] != 8'h00 || {1'b0, hdr_reg[5]} > 9'(PAL_DEPTH) ||
                (hdr_reg[7] != DEPTH_24 && hdr_reg[7] != DEPTH_32)) begin
                hcode = ST_BAD_HDR;
            end
        end else if (ptype == TGA_TRUE || ptype == TGA_TRUE_RLE) begin
            if (hdr_reg[1] != 8'h00 || hdr_reg[5] != 8'h00 || hdr_reg[6] != 8'h00 ||
                (hdr_reg[16] != DEPTH_24 && hdr_reg[16] != DEPTH_32)) begin
                hcode = ST_BAD_HDR;
            end
        end else begin
            hcode = ST_BAD_TYPE;
        end
    end

    assign out_free = !ovalid_reg || m_axis_tready;

    always_comb begin
        stat.last_hdr_byte   = (pos_reg == HDR_PW'(HDR_LEN - 1));
        stat.id_last         = (rem_reg <= 8'd1);
        stat.id_nz           = (hdr_reg[0] != 8'h00);
        stat.is_pal          = (ptype == TGA_CMAP || ptype == TGA_CMAP_RLE);
        stat.is_rle          = (ptype == TGA_CMAP_RLE || ptype == TGA_TRUE_RLE);
        stat.pal_nz          = (hdr_reg[5] != 8'h00);
        stat.asm_full_pal    = ({3'b000, acnt_reg} + 5'd1) >= nb_pal;
        stat.asm_full_pix    = ({3'b000, acnt_reg} + 5'd1) >= nb_pix;
        stat.pal_fill_done   = (loaded_inc >= {1'b0, hdr_reg[5]});
        stat.idx_bad         = (byte_reg >= hdr_reg[5]) ||
                               ({1'b0, byte_reg} >= 9'(PAL_DEPTH));
        stat.hdr_code        = hcode;
        stat.runset_rem_zero = rep_reg || (rem_reg <= 8'd1);
        stat.seg_wrap        = (col_sum >= {1'b0, w});
        stat.seg_row_more    = (row_inc < {1'b0, h});
        stat.seg_full        = (done_sum >= {1'b0, total_reg});
        stat.seg_left_zero   = (left_reg == seg);
        stat.left_nz         = (left_reg != 8'h00);
        stat.end_flag        = end_reg;
        stat.out_free        = out_free;
    end

    always_comb begin
        byte_next   = byte_reg;
        end_next    = end_reg;
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        loaded_next = loaded_reg;
        asm_next    = asm_reg;
        acnt_next   = acnt_reg;
        rem_next    = rem_reg;
        rep_next    = rep_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        left_next   = left_reg;
        argb_next   = argb_reg;
        pal_we      = 1'b0;
        case (cmd.op)
            OP_TAKE: begin
                byte_next = s_axis_tdata;
                end_next  = s_axis_tlast;
            end
            OP_HDR_WR: begin
                if (pos_reg < HDR_PW'(HDR_LEN)) begin
                    hdr_next[pos_reg] = byte_reg;
                end
                pos_next = pos_reg + HDR_PW'(1);
            end
            OP_ID_DEC: begin
                if (rem_reg != 8'h00) begin
                    rem_next = rem_reg - 8'd1;
                end
            end
            OP_PAL_ASM: begin
                if (stat.asm_full_pal) begin
                    pal_we      = (loaded_reg < 9'(PAL_DEPTH));
                    loaded_next = loaded_inc;
                    asm_next    = 24'h0;
                    acnt_next   = 2'd0;
                end else begin
                    asm_next  = asm_part;
                    acnt_next = acnt_reg + 2'd1;
                end
            end
            OP_PIX_ASM: begin
                if (stat.asm_full_pix) begin
                    argb_next = val_pix;
                    asm_next  = 24'h0;
                    acnt_next = 2'd0;
                end else begin
                    asm_next  = asm_part;
                    acnt_next = acnt_reg + 2'd1;
                end
            end
            OP_PKT_HDR: begin
                if (byte_reg > 8'(RAW_MAX)) begin
                    rep_next = 1'b1;
                    rem_next = byte_reg - 8'(RAW_MAX);
                end else begin
                    rep_next = 1'b0;
                    rem_next = byte_reg + 8'd1;
                end
            end
            OP_RUN_SET: begin
                if (stat.is_pal) begin
                    argb_next = pal_rd_reg;
                end
                if (!stat.is_rle) begin
                    left_next = 8'd1;
                end else if (rep_reg) begin
                    left_next = rem_reg;
                    rem_next  = 8'h00;
                end else begin
                    left_next = 8'd1;
                    if (rem_reg != 8'h00) begin
                        rem_next = rem_reg - 8'd1;
                    end
                end
            end
            OP_SEG: begin
                if (stat.seg_wrap) begin
                    col_next = 16'h0000;
                    row_next = row_inc[15:0];
                end else begin
                    col_next = col_sum[15:0];
                end
                done_next = done_sum[31:0];
                left_next = left_reg - seg;
            end
            OP_ROW_MUL: begin
                base_next = prod;
            end
            OP_TOTAL_MUL: begin
                total_next = prod;
            end
            OP_BASE0: begin
                base_next = prod;
                row_next  = 16'h0000;
                col_next  = 16'h0000;
                done_next = 32'h0;
            end
            OP_ENTER_ID: begin
                rem_next = hdr_reg[0];
            end
            OP_ENTER_PAL: begin
                loaded_next = 9'h000;
                asm_next    = 24'h0;
                acnt_next   = 2'd0;
            end
            OP_ENTER_PIX: begin
                asm_next  = 24'h0;
                acnt_next = 2'd0;
                rem_next  = 8'h00;
                rep_next  = 1'b0;
            end
            OP_CLEAR: begin
                pos_next    = '0;
                for (int i = 0; i < HDR_LEN; i++) begin
                    hdr_next[i] = 8'h00;
                end
                loaded_next = 9'h000;
                asm_next    = 24'h0;
                acnt_next   = 2'd0;
                rem_next    = 8'h00;
                rep_next    = 1'b0;
                row_next    = 16'h0000;
                col_next    = 16'h0000;
                base_next   = 32'h0;
                done_next   = 32'h0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        ow_next     = ow_reg;
        oh_next     = oh_reg;
        oidx_next   = oidx_reg;
        ocnt_next   = ocnt_reg;
        oargb_next  = oargb_reg;
        olast_next  = olast_reg;
        if (cmd.emit) begin
            ovalid_next = 1'b1;
            okind_next  = cmd.kind;
            ostat_next  = cmd.status;
            ow_next     = w;
            oh_next     = h;
            olast_next  = cmd.last;
            if (cmd.kind == K_RUN) begin
                oidx_next  = base_reg + {16'h0000, col_reg};
                ocnt_next  = seg;
                oargb_next = argb_reg;
            end else begin
                oidx_next  = 32'h0;
                ocnt_next  = 8'h00;
                oargb_next = 32'h0;
            end
        end else if (m_axis_tready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg    <= 1'b0;
            pos_reg    <= '0;
            for (int i = 0; i < HDR_LEN; i++) begin
                hdr_reg[i] <= 8'h00;
            end
            loaded_reg <= 9'h000;
            asm_reg    <= 24'h0;
            acnt_reg   <= 2'd0;
            rem_reg    <= 8'h00;
            rep_reg    <= 1'b0;
            row_reg    <= 16'h0000;
            col_reg    <= 16'h0000;
            base_reg   <= 32'h0;
            done_reg   <= 32'h0;
            ovalid_reg <= 1'b0;
        end else begin
            end_reg    <= end_next;
            pos_reg    <= pos_next;
            hdr_reg    <= hdr_next;
            loaded_reg <= loaded_next;
            asm_reg    <= asm_next;
            acnt_reg   <= acnt_next;
            rem_reg    <= rem_next;
            rep_reg    <= rep_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            base_reg   <= base_next;
            done_reg   <= done_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        total_reg <= total_next;
        left_reg  <= left_next;
        argb_reg  <= argb_next;
        okind_reg <= okind_next;
        ostat_reg <= ostat_next;
        ow_reg    <= ow_next;
        oh_reg    <= oh_next;
        oidx_reg  <= oidx_next;
        ocnt_reg  <= ocnt_next;
        oargb_reg <= oargb_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[loaded_reg[PAL_AW-1:0]] <= val_pal;
        end
        pal_rd_reg <= pal_mem[byte_reg[PAL_AW-1:0]];
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {5'b00000, oargb_reg, ocnt_reg, oidx_reg, oh_reg, ow_reg, ostat_reg};

    `TGAD_ASSERT_NOW(a_seg_nonzero, cmd.op == OP_SEG, seg != 8'h00,
        "run segment of zero pixels")
    `TGAD_ASSERT_NOW(a_run_count, m_axis_tvalid && m_axis_tuser == K_RUN,
        ocnt_reg != 8'h00, "pixel run result with zero count")

endmodule

`default_nettype wire

// ===== hw/rtl/tgad_ctrl.sv =====
// Controller state machine of the TGA decoder: file phase and per-byte sequencing.
`default_nettype none
`include "tga_image_decoder_defines.svh"

module tgad_ctrl import tgad_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    status_t     err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_HEADER;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        s_axis_tready = 1'b0;
        cmd.op        = OP_NONE;
        cmd.emit      = 1'b0;
        cmd.kind      = K_DONE;
        cmd.status    = ST_OK;
        cmd.last      = 1'b1;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.op     = OP_TAKE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                case (phase_reg)
                    PH_HEADER: begin
                        cmd.op = OP_HDR_WR;
                        if (stat.last_hdr_byte) begin
                            state_next = S_HCHECK;
                        end
                    end
                    PH_ID: begin
                        cmd.op = OP_ID_DEC;
                        if (stat.id_last) begin
                            state_next = S_AFTER_ID;
                        end
                    end
                    PH_PAL: begin
                        cmd.op = OP_PAL_ASM;
                        if (stat.asm_full_pal && stat.pal_fill_done) begin
                            state_next = S_ENTPIX;
                        end
                    end
                    PH_PACKET: begin
                        cmd.op     = OP_PKT_HDR;
                        phase_next = PH_PIXEL;
                    end
                    PH_PIXEL: begin
                        if (stat.is_pal) begin
                            if (stat.idx_bad) begin
                                err_next   = ST_BAD_INDEX;
                                state_next = S_ERR;
                            end else begin
                                state_next = S_RUNSET;
                            end
                        end else begin
                            cmd.op = OP_PIX_ASM;
                            if (stat.asm_full_pix) begin
                                state_next = S_RUNSET;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_HCHECK: begin
                if (stat.hdr_code != ST_OK) begin
                    err_next   = stat.hdr_code;
                    state_next = S_ERR;
                end else begin
                    state_next = S_HTOTAL;
                end
            end
            S_HTOTAL: begin
                cmd.op     = OP_TOTAL_MUL;
                state_next = S_HBASE;
            end
            S_HBASE: begin
                cmd.op     = OP_BASE0;
                state_next = S_HOK;
            end
            S_HOK: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_SIZE;
                    cmd.last = !stat.end_flag;
                    if (stat.id_nz) begin
                        cmd.op     = OP_ENTER_ID;
                        phase_next = PH_ID;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_AFTER_ID;
                    end
                end
            end
            S_AFTER_ID: begin
                if (stat.is_pal && stat.pal_nz) begin
                    cmd.op     = OP_ENTER_PAL;
                    phase_next = PH_PAL;
                    state_next = S_FIN;
                end else begin
                    state_next = S_ENTPIX;
                end
            end
            S_ENTPIX: begin
                cmd.op     = OP_ENTER_PIX;
                phase_next = stat.is_rle ? PH_PACKET : PH_PIXEL;
                state_next = S_FIN;
            end
            S_RUNSET: begin
                cmd.op = OP_RUN_SET;
                if (stat.is_rle && stat.runset_rem_zero) begin
                    phase_next = PH_PACKET;
                end
                state_next = S_SEG;
            end
            S_SEG: begin
                if (stat.out_free) begin
                    cmd.op   = OP_SEG;
                    cmd.emit = 1'b1;
                    cmd.kind = K_RUN;
                    cmd.last = stat.seg_left_zero && !stat.seg_full && !stat.end_flag;
                    if (stat.seg_wrap && stat.seg_row_more) begin
                        state_next = S_ROWMUL;
                    end else if (stat.seg_full) begin
                        state_next = S_FINOK;
                    end else if (stat.seg_left_zero) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ROWMUL: begin
                cmd.op     = OP_ROW_MUL;
                state_next = stat.left_nz ? S_SEG : S_FIN;
            end
            S_FINOK: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_OK;
                    phase_next = PH_DONE;
                    state_next = S_FIN;
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.status = err_reg;
                    phase_next = PH_DONE;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!stat.end_flag) begin
                    state_next = S_IDLE;
                end else if (phase_reg == PH_DONE || stat.out_free) begin
                    if (phase_reg != PH_DONE) begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_TRUNC;
                    end
                    cmd.op     = OP_CLEAR;
                    phase_next = PH_HEADER;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TGAD_ASSERT_NXT(a_accept_exec, s_axis_tvalid && s_axis_tready, state_reg == S_EXEC,
        "accepted byte not executed next cycle")
    `TGAD_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free,
        "result issued while output register is occupied")
    `TGAD_ASSERT_NXT(a_clear_header, cmd.op == OP_CLEAR, phase_reg == PH_HEADER,
        "end of file did not return to header phase")

endmodule

`default_nettype wire

// ===== hw/rtl/tga_image_decoder.sv =====
// Top level of the streaming TGA image decoder.
//
// The input stream carries one file byte per transaction in s_axis_tdata; s_axis_tlast
// marks the last byte of a file. The output stream carries one result per
// transaction: m_axis_tuser gives its kind (image size, pixel run, or finished with
// a status), and m_axis_tlast marks the last result caused by one input byte.
// A byte is taken in the idle state and then worked on in the execute state and those
// after it before the next byte is accepted. A byte that causes no result passes the
// take, execute and finish states; a header end also passes the header check, the total
// and base index products and the size result, and each pixel run adds one segment step
// per row segment, plus one multiplier step to find the next row's base index whenever a
// row completes. No new byte is taken before the controller is through with the last one.
// Palette lookups read a registered memory addressed by the latched byte.
// When the receiver stalls, the controller holds in its emitting state and takes no
// new byte; the last result of a byte may still wait in the output register while
// the next byte is accepted.
// Reset clears the controller to the header phase and all counters but the pixels left in
// the run and the pixel total; the palette memory is not cleared and holds garbage until a color map loads it.

`default_nettype none

module tga_image_decoder import tgad_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Fields from bit 0: data_byte[7:0].
    input  wire logic [7:0]         s_axis_tdata,
    input  wire logic               s_axis_tlast,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0: status[2:0], image_width[18:3], image_height[34:19],
    // pixel_index[66:35], run_count[74:67], pixel_argb[106:75], zero fill above.
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: kind[1:0].
    output logic [1:0]              m_axis_tuser,
    output logic                    m_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller owns the file phase and issues one datapath command per cycle.
    tgad_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds the header, palette, counters and the output register.
    tgad_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
